/* src/ctcl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ctcl_pkg: shared definitions of the code text class lexer
// Class codes, keyword table and character constants used by the cells,
// the lexer core and the top level.
// ----------------------------------------------------------------------------
package ctcl_pkg;

    localparam int LOOKAHEAD_DEFAULT = 9;
    localparam int NUM_WORDS         = 32;
    localparam int KW_MAX_LEN        = 9;
    // keyword_left counter and keyword length width
    localparam int KLW               = 4;

    typedef enum logic [2:0] {
        CLS_PLAIN   = 3'd0,
        CLS_COMMENT = 3'd1,
        CLS_STRING  = 3'd2,
        CLS_DIGIT   = 3'd3,
        CLS_PREPROC = 3'd4,
        CLS_KEYWORD = 3'd5
    } class_t;

    // Window control handed to the lexer core
    typedef struct packed {
        logic pop;        // head byte is classified this cycle
        logic line_done;  // head byte is the last byte of its line
    } ctl_t;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Keywords in priority order; the first match wins
    localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [NUM_WORDS] = '{
        "int", "float", "char", "string", "double", "class", "for", "if",
        "while", "do", "break", "virtual", "this", "else", "delete", "case",
        "switch", "new", "protected", "private", "public", "bool", "true",
        "false", "return", "using", "namespace", "throw", "void", "struct",
        "const", "mutable"
    };

    localparam logic [KLW-1:0] KW_LEN [NUM_WORDS] = '{
        4'd3, 4'd5, 4'd4, 4'd6, 4'd6, 4'd5, 4'd3, 4'd2,
        4'd5, 4'd2, 4'd5, 4'd7, 4'd4, 4'd4, 4'd6, 4'd4,
        4'd6, 4'd3, 4'd9, 4'd7, 4'd6, 4'd4, 4'd4,
        4'd5, 4'd6, 4'd5, 4'd9, 4'd5, 4'd4, 4'd6,
        4'd5, 4'd7
    };

    // Character k of keyword w, zero beyond its end
    function automatic logic [7:0] kw_char(input int w, input int k);
        if (k >= int'(KW_LEN[w]))
        begin
            return 8'h00;
        end
        return KW_TEXT[w][8*(int'(KW_LEN[w]) - 1 - k) +: 8];
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A))
            || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

endpackage
`default_nettype wire

/* src/ctcl_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ctcl_if: channel interfaces of the code text class lexer
// Text byte channel and character class channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ctcl_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       line_end;

    modport source (output valid, output char_code, output line_end, input ready);
    modport sink   (input valid, input char_code, input line_end, output ready);
endinterface

interface ctcl_class_if;
    logic       valid;
    logic       ready;
    logic [2:0] char_class;
    logic       line_last;

    modport source (output valid, output char_class, output line_last, input ready);
    modport sink   (input valid, input char_class, input line_last, output ready);
endinterface
`default_nettype wire

/* src/code_text_class_lexer_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// code_text_class_lexer_unit: source text character classifier
// Row of lookahead cells feeding a lexer core, with a registered result beat.
// ----------------------------------------------------------------------------
// One text byte is accepted per cycle and, once the lookahead row holds
// LOOKAHEAD bytes, one class beat leaves per cycle, so a line streams at one
// character per clock while result.ready holds high. A byte marked as line
// end starts a flush of the row: the bytes still held (up to LOOKAHEAD)
// leave one per cycle, and input is held back during the flush except on
// its final beat. A byte's class appears LOOKAHEAD - 1 bytes later or at
// its line end, and is then registered into the result beat. Lexer mode
// survives across lines; rest-of-line colouring and keyword runs stop at
// each line end.
// ----------------------------------------------------------------------------
module code_text_class_lexer_unit
    import ctcl_pkg::*;
#(
    parameter int LOOKAHEAD = LOOKAHEAD_DEFAULT
)
(
    input  wire             clk,
    input  wire             rst_n,
    ctcl_text_if.sink       text,
    ctcl_class_if.source    result
);

    localparam int FW = $clog2(LOOKAHEAD + 1);

    logic [FW-1:0] fill_reg, fill_next;
    logic          flush_reg, flush_next;
    logic          out_valid_reg;
    class_t        out_class_reg;
    logic          out_last_reg;

    logic          emit, slot_free, pop, push, last_beat;
    logic [FW-1:0] push_idx;
    ctl_t          ctl;
    class_t        cls;

    logic [7:0]           cell_data [LOOKAHEAD];
    logic [NUM_WORDS-1:0] cell_eq   [LOOKAHEAD];

    assign emit      = flush_reg || (fill_reg == FW'(LOOKAHEAD));
    assign slot_free = !out_valid_reg || result.ready;
    assign pop       = emit && slot_free;
    assign last_beat = flush_reg && (fill_reg == FW'(1));
    assign push      = text.valid && text.ready;
    assign push_idx  = pop ? (fill_reg - FW'(1)) : fill_reg;

    assign text.ready = flush_reg ? (last_beat && pop)
                                  : ((fill_reg != FW'(LOOKAHEAD)) || pop);

    assign ctl.pop       = pop;
    assign ctl.line_done = last_beat;

    genvar k;
    generate
        for (k = 0; k < LOOKAHEAD; k++)
        begin : g_cell
            logic [7:0] nbr;
            if (k == LOOKAHEAD - 1)
            begin : g_tail
                assign nbr = text.char_code;
            end
            else
            begin : g_mid
                assign nbr = cell_data[k + 1];
            end

            ctcl_cell #(
                .POS (k)
            ) u_cell (
                .clk      (clk),
                .load     (push && (push_idx == FW'(k))),
                .shift    (pop),
                .in_data  (text.char_code),
                .nbr_data (nbr),
                .data     (cell_data[k]),
                .eq       (cell_eq[k])
            );
        end
    endgenerate

    ctcl_lexer #(
        .LOOKAHEAD (LOOKAHEAD),
        .FW        (FW)
    ) u_lexer (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .head  (cell_data[0]),
        .nxt   (cell_data[1]),
        .avail (fill_reg),
        .eq    (cell_eq),
        .cls   (cls)
    );

    always_comb
    begin
        fill_next = fill_reg;
        if (pop && !push)
        begin
            fill_next = fill_reg - FW'(1);
        end
        else if (push && !pop)
        begin
            fill_next = fill_reg + FW'(1);
        end

        flush_next = flush_reg;
        priority if (push)
        begin
            flush_next = text.line_end;
        end
        else if (pop && last_beat)
        begin
            flush_next = 1'b0;
        end
        else
        begin
            flush_next = flush_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            flush_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg  <= fill_next;
            flush_reg <= flush_next;
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_class_reg <= cls;
            out_last_reg  <= last_beat;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.char_class = out_class_reg;
    assign result.line_last  = out_last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(LOOKAHEAD))
        else $error("lookahead fill beyond window size");

    a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        flush_reg |-> (fill_reg != '0))
        else $error("flush active with an empty window");

    a_line_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && last_beat && !push) |=> (fill_reg == '0 && !flush_reg))
        else $error("window not empty after final flush beat");

    a_room_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!flush_reg && fill_reg != FW'(LOOKAHEAD)) |-> text.ready)
        else $error("text beat held back while the window has room");

endmodule
`default_nettype wire

/* src/ctcl_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ctcl_cell: one lookahead window cell
// Holds one text byte, takes its neighbour's byte on a shift, and compares
// its byte with every keyword's character at this cell's position.
// ----------------------------------------------------------------------------
module ctcl_cell
    import ctcl_pkg::*;
#(
    parameter int POS = 0
)
(
    input  wire                   clk,
    input  wire                   load,
    input  wire                   shift,
    input  wire  [7:0]            in_data,
    input  wire  [7:0]            nbr_data,
    output logic [7:0]            data,
    output logic [NUM_WORDS-1:0]  eq
);

    logic [7:0] data_reg;
    logic [7:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        priority if (load)
        begin
            data_next = in_data;
        end
        else if (shift)
        begin
            data_next = nbr_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

    genvar w;
    generate
        for (w = 0; w < NUM_WORDS; w++)
        begin : g_word
            localparam logic [7:0] KC = kw_char(w, POS);
            assign eq[w] = (data_reg == KC);
        end
    endgenerate

endmodule
`default_nettype wire

/* src/ctcl_lexer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ctcl_lexer: lexer core
// Classifies the window's head byte from the lexer mode, pending keyword
// bytes, rest-of-line colouring and the cells' keyword compares.
// ----------------------------------------------------------------------------
module ctcl_lexer
    import ctcl_pkg::*;
#(
    parameter int LOOKAHEAD = LOOKAHEAD_DEFAULT,
    parameter int FW        = $clog2(LOOKAHEAD + 1)
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  ctl_t                  ctl,
    input  wire  [7:0]            head,
    input  wire  [7:0]            nxt,
    input  wire  [FW-1:0]         avail,
    input  wire  [NUM_WORDS-1:0]  eq [LOOKAHEAD],
    output class_t                cls
);

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_BLOCK  = 2'd1,
        MODE_STRING = 2'd2,
        MODE_CLOSE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ROL_NONE    = 2'd0,
        ROL_COMMENT = 2'd1,
        ROL_PREPROC = 2'd2
    } rol_t;

    mode_t          mode_reg, mode_next;
    rol_t           rol_reg, rol_next;
    logic [KLW-1:0] kwl_reg, kwl_next;
    logic [7:0]     prev_reg;
    logic           als_reg;

    logic [KW_MAX_LEN-1:0] term [NUM_WORDS];
    logic [NUM_WORDS-1:0]  kw_hit;
    logic [KLW-1:0]        kw_len;
    logic                  has_next;
    logic                  is_quote;

    genvar w, k;
    generate
        for (w = 0; w < NUM_WORDS; w++)
        begin : g_word
            for (k = 0; k < KW_MAX_LEN; k++)
            begin : g_pos
                if (k >= int'(KW_LEN[w]))
                begin : g_past
                    assign term[w][k] = 1'b1;
                end
                else if (k < LOOKAHEAD)
                begin : g_cell
                    assign term[w][k] = eq[k][w];
                end
                else
                begin : g_short
                    assign term[w][k] = 1'b0;
                end
            end
            assign kw_hit[w] = (&term[w]) && (5'(KW_LEN[w]) <= 5'(avail));
        end
    endgenerate

    // first keyword in list order wins
    always_comb
    begin
        kw_len = '0;
        for (int i = NUM_WORDS - 1; i >= 0; i--)
        begin
            if (kw_hit[i])
            begin
                kw_len = KW_LEN[i];
            end
        end
    end

    assign has_next = (avail > FW'(1));
    assign is_quote = (head == CH_DQUOTE) || (head == CH_SQUOTE);

    always_comb
    begin
        cls       = CLS_PLAIN;
        mode_next = mode_reg;
        rol_next  = rol_reg;
        kwl_next  = kwl_reg;
        if (rol_reg != ROL_NONE)
        begin
            cls = (rol_reg == ROL_COMMENT) ? CLS_COMMENT : CLS_PREPROC;
        end
        else if (kwl_reg != '0)
        begin
            cls      = CLS_KEYWORD;
            kwl_next = kwl_reg - KLW'(1);
        end
        else
        begin
            unique case (mode_reg)
                MODE_CLOSE:
                begin
                    cls       = CLS_COMMENT;
                    mode_next = MODE_NORMAL;
                end
                MODE_BLOCK:
                begin
                    cls = CLS_COMMENT;
                    if (head == CH_STAR && has_next && nxt == CH_SLASH)
                    begin
                        mode_next = MODE_CLOSE;
                    end
                end
                MODE_STRING:
                begin
                    cls = CLS_STRING;
                    // an escaped quote only counts after a backslash on the same line
                    if (is_quote && !(!als_reg && prev_reg == CH_BSLASH))
                    begin
                        mode_next = MODE_NORMAL;
                    end
                end
                MODE_NORMAL:
                begin
                    priority if (head == CH_SLASH && has_next && nxt == CH_SLASH)
                    begin
                        cls      = CLS_COMMENT;
                        rol_next = ROL_COMMENT;
                    end
                    else if (head == CH_HASH)
                    begin
                        cls      = CLS_PREPROC;
                        rol_next = ROL_PREPROC;
                    end
                    else if (is_digit(head))
                    begin
                        cls = CLS_DIGIT;
                    end
                    else if (head == CH_SLASH && has_next && nxt == CH_STAR)
                    begin
                        cls       = CLS_COMMENT;
                        mode_next = MODE_BLOCK;
                    end
                    else if (is_quote)
                    begin
                        cls       = CLS_STRING;
                        mode_next = MODE_STRING;
                    end
                    else if ((als_reg || !is_alnum(prev_reg)) && kw_len != '0)
                    begin
                        cls      = CLS_KEYWORD;
                        kwl_next = kw_len - KLW'(1);
                    end
                    else
                    begin
                        cls = CLS_PLAIN;
                    end
                end
                default:
                begin
                    cls = CLS_PLAIN;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
            rol_reg  <= ROL_NONE;
            kwl_reg  <= '0;
            prev_reg <= '0;
            als_reg  <= 1'b1;
        end
        else if (ctl.pop)
        begin
            prev_reg <= head;
            als_reg  <= ctl.line_done;
            if (ctl.line_done)
            begin
                // drop pending keyword bytes and rest-of-line colouring
                mode_reg <= (mode_next == MODE_CLOSE) ? MODE_NORMAL : mode_next;
                rol_reg  <= ROL_NONE;
                kwl_reg  <= '0;
            end
            else
            begin
                mode_reg <= mode_next;
                rol_reg  <= rol_next;
                kwl_reg  <= kwl_next;
            end
        end
    end

endmodule
`default_nettype wire
